// ----- design/lsbpsc_pkg.sv -----
package lsbpsc_pkg;

    localparam int BYTE_BITS = 8;
    localparam int NUM_LANES = 3;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_PUSH    = 2'd1,
        MODE_EMBED   = 2'd2,
        MODE_EXTRACT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_DROPPED  = 2'd2
    } status_t;

    // per-lane embed control
    typedef struct packed {
        logic en;
        logic msg_bit;
    } lane_ctl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       char_valid;
        logic [7:0] char_value;
        logic       message_done;
        status_t    status;
    } result_t;

endpackage

// ----- design/lsbpsc_lane.sv -----
module lsbpsc_lane
(
    input  logic                  [7:0] chan_in,
    input  lsbpsc_pkg::lane_ctl_t       ctl,
    output logic                  [7:0] chan_out,
    output logic                        lsb
);

    // add one when the low bit has to flip
    always_comb
    begin
        lsb = chan_in[0];
        if (ctl.en && (chan_in[0] != ctl.msg_bit))
        begin
            chan_out = chan_in + 8'd1;
        end
        else
        begin
            chan_out = chan_in;
        end
    end

endmodule

// ----- design/lsbpsc_merge.sv -----
module lsbpsc_merge #(
    parameter int BUFFER_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  lsbpsc_pkg::mode_t     mode,
    input  logic            [7:0] byte_value,
    input  logic                  is_last_byte,
    input  logic            [7:0] lane_chan [lsbpsc_pkg::NUM_LANES],
    input  logic                  lane_lsb  [lsbpsc_pkg::NUM_LANES],
    output lsbpsc_pkg::lane_ctl_t lane_ctl  [lsbpsc_pkg::NUM_LANES],
    output lsbpsc_pkg::result_t   result
);

    localparam int HW = $clog2(BUFFER_BITS + 1);

    typedef logic [HW-1:0] held_t;
    typedef logic [HW:0]   sum_t;

    localparam sum_t BUF_LIM  = sum_t'(BUFFER_BITS);
    localparam sum_t BYTE_SUM = sum_t'(lsbpsc_pkg::BYTE_BITS);

    logic [BUFFER_BITS-1:0] buf_reg, buf_next;
    held_t                  held_reg, held_next;
    logic                   last_seen_reg, last_seen_next;
    logic                   term_q_reg, term_q_next;
    logic                   emb_done_reg, emb_done_next;
    logic             [7:0] asm_reg, asm_next;
    logic             [2:0] asm_cnt_reg, asm_cnt_next;
    logic                   ext_done_reg, ext_done_next;

    logic                   push_room;
    logic                   push_ok;
    held_t                  held_base;
    logic                   last_base;
    logic                   term_room;
    logic                   term_add;
    held_t                  held_q;
    logic                   term_q;
    logic                   do_embed;
    logic             [1:0] n_used;
    logic [BUFFER_BITS-1:0] push_vec;
    logic [BUFFER_BITS-1:0] buf_base;
    logic             [7:0] ab;
    logic             [2:0] ac;
    logic                   xf;
    logic                   cv;
    logic             [7:0] cval;

    always_comb
    begin
        push_room = (sum_t'(held_reg) + BYTE_SUM) <= BUF_LIM;
        push_ok   = (mode == lsbpsc_pkg::MODE_PUSH) && !last_seen_reg && push_room;
        push_vec  = {{(BUFFER_BITS-8){1'b0}}, byte_value} << held_reg;

        // state after a push, before the terminator check
        held_base = push_ok ? held_t'(sum_t'(held_reg) + BYTE_SUM) : held_reg;
        last_base = last_seen_reg || (push_ok && is_last_byte);
        buf_base  = push_ok ? (buf_reg | push_vec) : buf_reg;

        // terminator is eight zero bits above the held ones
        term_room = (sum_t'(held_base) + BYTE_SUM) <= BUF_LIM;
        term_add  = ((mode == lsbpsc_pkg::MODE_PUSH && push_ok)
                    || mode == lsbpsc_pkg::MODE_EMBED)
                    && last_base && !term_q_reg && term_room;
        held_q    = term_add ? held_t'(sum_t'(held_base) + BYTE_SUM) : held_base;
        term_q    = term_q_reg || term_add;

        do_embed  = (mode == lsbpsc_pkg::MODE_EMBED) && !emb_done_reg
                    && (term_q || held_q >= held_t'(3));
        n_used    = (held_q >= held_t'(3)) ? 2'd3 : held_q[1:0];

        for (int i = 0; i < lsbpsc_pkg::NUM_LANES; i++)
        begin
            lane_ctl[i].en      = do_embed && (held_q > held_t'(i));
            lane_ctl[i].msg_bit = buf_base[i];
        end

        // extraction: at most one byte completes per pixel
        ab   = asm_reg;
        ac   = asm_cnt_reg;
        xf   = ext_done_reg;
        cv   = 1'b0;
        cval = 8'd0;
        for (int k = 0; k < lsbpsc_pkg::NUM_LANES; k++)
        begin
            if (!xf)
            begin
                ab[ac] = lane_lsb[k];
                if (ac == 3'd7)
                begin
                    if (ab == 8'd0)
                    begin
                        xf = 1'b1;
                    end
                    else
                    begin
                        cv   = 1'b1;
                        cval = ab;
                    end
                    ab = 8'd0;
                    ac = 3'd0;
                end
                else
                begin
                    ac = ac + 3'd1;
                end
            end
        end

        buf_next       = buf_reg;
        held_next      = held_reg;
        last_seen_next = last_seen_reg;
        term_q_next    = term_q_reg;
        emb_done_next  = emb_done_reg;
        asm_next       = asm_reg;
        asm_cnt_next   = asm_cnt_reg;
        ext_done_next  = ext_done_reg;

        result              = '0;
        result.status       = lsbpsc_pkg::ST_OK;

        unique case (mode)
            lsbpsc_pkg::MODE_START:
            begin
                buf_next       = '0;
                held_next      = '0;
                last_seen_next = 1'b0;
                term_q_next    = 1'b0;
                emb_done_next  = 1'b0;
                asm_next       = 8'd0;
                asm_cnt_next   = 3'd0;
                ext_done_next  = 1'b0;
            end
            lsbpsc_pkg::MODE_PUSH:
            begin
                buf_next       = buf_base;
                held_next      = held_q;
                last_seen_next = last_base;
                term_q_next    = term_q;
                result.message_done = emb_done_reg;
                if (!push_ok)
                begin
                    result.status = lsbpsc_pkg::ST_DROPPED;
                end
            end
            lsbpsc_pkg::MODE_EMBED:
            begin
                term_q_next   = term_q;
                held_next     = held_q;
                result.red    = lane_chan[0];
                result.green  = lane_chan[1];
                result.blue   = lane_chan[2];
                if (do_embed)
                begin
                    held_next = held_q - held_t'(n_used);
                    unique case (n_used)
                        2'd0:    buf_next = buf_base;
                        2'd1:    buf_next = buf_base >> 1;
                        2'd2:    buf_next = buf_base >> 2;
                        default: buf_next = buf_base >> 3;
                    endcase
                    emb_done_next = term_q && (held_q == held_t'(n_used));
                end
                else if (!emb_done_reg)
                begin
                    result.status = lsbpsc_pkg::ST_UNDERRUN;
                end
                result.message_done = emb_done_next;
            end
            default:
            begin
                asm_next            = ab;
                asm_cnt_next        = ac;
                ext_done_next       = xf;
                result.red          = lane_chan[0];
                result.green        = lane_chan[1];
                result.blue         = lane_chan[2];
                result.char_valid   = cv;
                result.char_value   = cval;
                result.message_done = xf;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            last_seen_reg <= 1'b0;
            term_q_reg    <= 1'b0;
            emb_done_reg  <= 1'b0;
            asm_reg       <= 8'd0;
            asm_cnt_reg   <= 3'd0;
            ext_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            last_seen_reg <= last_seen_next;
            term_q_reg    <= term_q_next;
            emb_done_reg  <= emb_done_next;
            asm_reg       <= asm_next;
            asm_cnt_reg   <= asm_cnt_next;
            ext_done_reg  <= ext_done_next;
        end
    end

endmodule

// ----- design/lsb_pixel_stego_codec.sv -----
// channel  | dir | fields
// ---------+-----+-------------------------------------------------------------
// s_*      | in  | tuser: mode; tlast: is_last_byte;
//          |     | tdata: byte_value, red_in, green_in, blue_in
// m_*      | out | tuser: char_valid, status; tlast: message_done;
//          |     | tdata: red_out, green_out, blue_out, char_value
//
// one word in, one word out, one word per clock sustained while the output is
// taken; results held in the single output register behind the three lanes
// all state updates in the cycle a word is accepted; mode start clears it
// rst_n asynchronous: clears state and empties the output register
// a stalled output holds its word; input still accepted when the word leaves
module lsb_pixel_stego_codec #(
    parameter int BUFFER_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_value, red_in, green_in, blue_in
    input  logic  [1:0] s_tuser,   // mode
    input  logic        s_tlast,   // is_last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, char_value
    output logic  [2:0] m_tuser,   // char_valid, status
    output logic        m_tlast    // message_done
);

    logic                  accept;
    logic            [7:0] chan_in   [lsbpsc_pkg::NUM_LANES];
    logic            [7:0] chan_out  [lsbpsc_pkg::NUM_LANES];
    logic                  chan_lsb  [lsbpsc_pkg::NUM_LANES];
    lsbpsc_pkg::lane_ctl_t lane_ctl  [lsbpsc_pkg::NUM_LANES];
    lsbpsc_pkg::result_t   result;
    lsbpsc_pkg::result_t   result_reg;
    logic                  valid_reg, valid_next;

    // output register frees up whenever its word is taken
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign chan_in[0] = s_tdata[15:8];
    assign chan_in[1] = s_tdata[23:16];
    assign chan_in[2] = s_tdata[31:24];

    // one lane per color channel
    for (genvar g = 0; g < lsbpsc_pkg::NUM_LANES; g++)
    begin : g_lane
        lsbpsc_lane u_lane
        (
            .chan_in  (chan_in[g]),
            .ctl      (lane_ctl[g]),
            .chan_out (chan_out[g]),
            .lsb      (chan_lsb[g])
        );
    end

    // bit buffer, byte assembly and lane merge
    lsbpsc_merge #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (lsbpsc_pkg::mode_t'(s_tuser)),
        .byte_value   (s_tdata[7:0]),
        .is_last_byte (s_tlast),
        .lane_chan    (chan_out),
        .lane_lsb     (chan_lsb),
        .lane_ctl     (lane_ctl),
        .result       (result)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.char_value, result_reg.blue,
                       result_reg.green, result_reg.red};
    assign m_tuser  = {result_reg.status, result_reg.char_valid};
    assign m_tlast  = result_reg.message_done;

endmodule
